/* rtl/core/ssp_pkg.sv */
// Shared types and constants for the sprite screen projection block.
// No dependencies; imported by ssp_div and sprite_screen_projection.
`timescale 1ns / 1ps
package ssp_pkg;

  typedef enum logic [2:0] {
    REG_CAM_POS_X   = 3'd0,
    REG_CAM_POS_Y   = 3'd1,
    REG_CAM_DIR_X   = 3'd2,
    REG_CAM_DIR_Y   = 3'd3,
    REG_CAM_PLANE_X = 3'd4,
    REG_CAM_PLANE_Y = 3'd5,
    REG_VIEW_WIDTH  = 3'd6,
    REG_VIEW_HEIGHT = 3'd7
  } reg_idx_e;

  localparam int unsigned CfgIdxW = 4;

  localparam logic signed [31:0] CamPosXRst   = 32'sd0;
  localparam logic signed [31:0] CamPosYRst   = 32'sd0;
  localparam logic signed [15:0] CamDirXRst   = 16'sd0;
  localparam logic signed [15:0] CamDirYRst   = -16'sd16384;
  localparam logic signed [15:0] CamPlaneXRst = 16'sd10813;
  localparam logic signed [15:0] CamPlaneYRst = 16'sd0;
  localparam logic [12:0]        ViewWidthRst  = 13'd640;
  localparam logic [12:0]        ViewHeightRst = 13'd480;

  // Direction and plane vectors are Q2.14.
  localparam int unsigned DirFracBits = 14;

endpackage

/* rtl/core/ssp_div.sv */
// Pipelined signed restoring divider, one quotient bit per stage.
// Imports ssp_pkg; instantiated by sprite_screen_projection.
`timescale 1ns / 1ps
module ssp_div import ssp_pkg::*; #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 32,
  parameter int unsigned TagW = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic signed [DenW-1:0] den_i,
  input  logic [TagW-1:0]        tag_i,
  output logic                   valid_o,
  output logic signed [NumW-1:0] quot_o,
  output logic [TagW-1:0]        tag_o
);

  // Quotient rounds toward zero; den of zero gives an all-ones magnitude.
  logic [NumW:0]        vld_q;
  logic [NumW-1:0]      rem_q [NumW+1];
  logic [NumW-1:0]      quo_q [NumW+1];
  logic [DenW-1:0]      dmag_q [NumW+1];
  logic                 neg_q [NumW+1];
  logic [TagW-1:0]      tag_q [NumW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NumW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= '0;
    quo_q[0]  <= num_i[NumW-1] ? (~num_i + 1'b1) : num_i;
    dmag_q[0] <= den_i[DenW-1] ? (~den_i + 1'b1) : den_i;
    neg_q[0]  <= num_i[NumW-1] ^ den_i[DenW-1];
    tag_q[0]  <= tag_i;
  end

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [NumW:0] trial;
    logic [NumW:0] shifted;
    always_comb begin
      shifted = {rem_q[s], quo_q[s][NumW-1]};
      trial   = shifted - {{(NumW+1-DenW){1'b0}}, dmag_q[s]};
    end
    always_ff @(posedge clk_i) begin
      if (!trial[NumW]) begin
        rem_q[s+1] <= trial[NumW-1:0];
        quo_q[s+1] <= {quo_q[s][NumW-2:0], 1'b1};
      end else begin
        rem_q[s+1] <= shifted[NumW-1:0];
        quo_q[s+1] <= {quo_q[s][NumW-2:0], 1'b0};
      end
      dmag_q[s+1] <= dmag_q[s];
      neg_q[s+1]  <= neg_q[s];
      tag_q[s+1]  <= tag_q[s];
    end
  end

  assign valid_o = vld_q[NumW];
  assign quot_o  = neg_q[NumW] ? (~quo_q[NumW] + 1'b1) : quo_q[NumW];
  assign tag_o   = tag_q[NumW];

endmodule

/* rtl/core/sprite_screen_projection.sv */
// Sprite screen projection top level; depends on ssp_pkg and ssp_div.
// done_o rises once a sprite has passed the pipeline: three input stages, a 65-stage
// and a 49-stage divider, two middle stages and the output register.
// Throughput one sprite per clock; busy never rises, so beats can come back to back.
// Reset clears all pipeline valid bits and loads the default camera registers.
// The receiver cannot stall: each result beat shows for one cycle on done_o.
`timescale 1ns / 1ps
module sprite_screen_projection import ssp_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  obj_world_x_i,
  input  logic signed [31:0]  obj_world_y_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output logic                done_o,
  output logic                visible_o,
  output logic signed [31:0]  depth_o,
  output logic signed [15:0]  center_col_o,
  output logic [15:0]         obj_size_o,
  output logic signed [15:0]  start_col_o,
  output logic signed [15:0]  end_col_o,
  output logic signed [15:0]  start_row_o,
  output logic signed [15:0]  end_row_o
);

  // Pipeline overview:
  //  S1  offsets dx, dy (33 bit) and det (33 bit, exact product difference).
  //  S2  the four 16x33 products.
  //  S3  numx, numy; shifted by 14 bits to form the dividends.
  //  D1  two parallel 65-stage dividers give tx and depth.
  //  S4  saturate tx and depth to 32 bits; the second dividends are formed after it.
  //  S5  register the center dividend half_w*(depth+tx) and the size dividend.
  //  D2  two parallel 49-stage dividers by depth.
  //  S6  saturate, halve, clamp, and register the result beat.

  localparam int unsigned NumW1 = 64;  // 50-bit numerator << 14 fits in 64
  localparam int unsigned NumW2 = 48;  // 12b * 34b and 13b << 16 fit in 48
  localparam int unsigned Tag1W = 32 + 1 + 1;
  localparam int unsigned Tag2W = 1 + 32 + 13 + 13;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // ---------------- configuration registers ----------------
  logic signed [31:0] pos_x_q, pos_y_q;
  logic signed [15:0] dir_x_q, dir_y_q, pl_x_q, pl_y_q;
  logic [12:0]        vw_q, vh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= CamPosXRst;
      pos_y_q <= CamPosYRst;
      dir_x_q <= CamDirXRst;
      dir_y_q <= CamDirYRst;
      pl_x_q  <= CamPlaneXRst;
      pl_y_q  <= CamPlaneYRst;
      vw_q    <= ViewWidthRst;
      vh_q    <= ViewHeightRst;
    end else if (cfg_valid_i && cfg_index_i[CfgIdxW-1] == 1'b0) begin
      case (reg_idx_e'(cfg_index_i[2:0]))
        REG_CAM_POS_X:   pos_x_q <= cfg_data_i;
        REG_CAM_POS_Y:   pos_y_q <= cfg_data_i;
        REG_CAM_DIR_X:   dir_x_q <= cfg_data_i[15:0];
        REG_CAM_DIR_Y:   dir_y_q <= cfg_data_i[15:0];
        REG_CAM_PLANE_X: pl_x_q  <= cfg_data_i[15:0];
        REG_CAM_PLANE_Y: pl_y_q  <= cfg_data_i[15:0];
        REG_VIEW_WIDTH:  vw_q    <= cfg_data_i[12:0];
        REG_VIEW_HEIGHT: vh_q    <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // ---------------- S1: offsets and determinant ----------------
  logic               s1_vld_q, s2_vld_q, s3_vld_q;
  logic signed [32:0] dx_q, dy_q, det_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= 33'(obj_world_x_i) - 33'(pos_x_q);
    dy_q  <= 33'(obj_world_y_i) - 33'(pos_y_q);
    det_q <= 33'(pl_x_q) * 33'(dir_y_q) - 33'(dir_x_q) * 33'(pl_y_q);
  end

  // ---------------- S2: products ----------------
  logic signed [48:0] p_ydx_q, p_xdy_q, p_pxdy_q, p_pydx_q;
  logic signed [32:0] det2_q;

  always_ff @(posedge clk_i) begin
    p_ydx_q  <= 49'(dir_y_q) * 49'(dx_q);
    p_xdy_q  <= 49'(dir_x_q) * 49'(dy_q);
    p_pxdy_q <= 49'(pl_x_q) * 49'(dy_q);
    p_pydx_q <= 49'(pl_y_q) * 49'(dx_q);
    det2_q   <= det_q;
  end

  // ---------------- S3: dividends ----------------
  logic signed [NumW1-1:0] numx_q, numy_q;
  logic signed [32:0]      det3_q;

  always_ff @(posedge clk_i) begin
    numx_q <= NumW1'(p_ydx_q - p_xdy_q) <<< DirFracBits;
    numy_q <= NumW1'(p_pxdy_q - p_pydx_q) <<< DirFracBits;
    det3_q <= det2_q;
  end

  // ---------------- D1: tx and depth ----------------
  logic                    d1_vld, d1b_vld;
  logic signed [NumW1-1:0] tx_full, dp_full;
  logic [Tag1W-1:0]        d1_tag;
  logic [Tag1W-1:0]        d1b_tag;

  ssp_div #(.NumW(NumW1), .DenW(33), .TagW(Tag1W)) u_div_tx (
    .clk_i, .rst_ni, .valid_i(s3_vld_q), .num_i(numx_q), .den_i(det3_q),
    .tag_i({32'd0, det3_q == '0, 1'b0}),
    .valid_o(d1_vld), .quot_o(tx_full), .tag_o(d1_tag)
  );

  ssp_div #(.NumW(NumW1), .DenW(33), .TagW(Tag1W)) u_div_dp (
    .clk_i, .rst_ni, .valid_i(s3_vld_q), .num_i(numy_q), .den_i(det3_q),
    .tag_i({32'd0, det3_q == '0, 1'b0}),
    .valid_o(d1b_vld), .quot_o(dp_full), .tag_o(d1b_tag)
  );

  function automatic logic signed [31:0] sat32(input logic signed [NumW1-1:0] v);
    if (v > NumW1'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < -NumW1'(33'sh080000000)) return 32'sh80000000;
    return v[31:0];
  endfunction

  // ---------------- S4: second dividends ----------------
  logic                    s4_vld_q, s4_det0_q;
  logic signed [31:0]      tx_q, dp_q;
  logic [12:0]             vw4_q, vh4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_vld_q <= 1'b0;
    else         s4_vld_q <= d1_vld;
  end

  always_ff @(posedge clk_i) begin
    tx_q      <= sat32(tx_full);
    dp_q      <= sat32(dp_full);
    s4_det0_q <= d1_tag[1];
    vw4_q     <= vw_q;
    vh4_q     <= vh_q;
  end

  logic signed [NumW2-1:0] cnum, snum;
  logic signed [33:0]      dsum;
  always_comb begin
    dsum = 34'(dp_q) + 34'(tx_q);
    cnum = NumW2'($signed({1'b0, vw4_q[12:1]})) * NumW2'(dsum);
    snum = NumW2'({1'b0, vh4_q}) <<< FRAC_BITS;
  end

  logic                    s5_vld_q, s5_det0_q;
  logic signed [NumW2-1:0] cnum_q, snum_q;
  logic signed [31:0]      dp5_q;
  logic [12:0]             vw5_q, vh5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_vld_q <= 1'b0;
    else         s5_vld_q <= s4_vld_q;
  end

  always_ff @(posedge clk_i) begin
    cnum_q    <= cnum;
    snum_q    <= snum;
    dp5_q     <= dp_q;
    s5_det0_q <= s4_det0_q;
    vw5_q     <= vw4_q;
    vh5_q     <= vh4_q;
  end

  // ---------------- D2: center and size ----------------
  logic                    d2_vld, d2b_vld;
  logic signed [NumW2-1:0] cq, sq;
  logic [Tag2W-1:0]        d2_tag, d2b_tag;

  ssp_div #(.NumW(NumW2), .DenW(32), .TagW(Tag2W)) u_div_ctr (
    .clk_i, .rst_ni, .valid_i(s5_vld_q), .num_i(cnum_q), .den_i(dp5_q),
    .tag_i({s5_det0_q, dp5_q, vw5_q, vh5_q}),
    .valid_o(d2_vld), .quot_o(cq), .tag_o(d2_tag)
  );

  ssp_div #(.NumW(NumW2), .DenW(32), .TagW(Tag2W)) u_div_sz (
    .clk_i, .rst_ni, .valid_i(s5_vld_q), .num_i(snum_q), .den_i(dp5_q),
    .tag_i({s5_det0_q, dp5_q, vw5_q, vh5_q}),
    .valid_o(d2b_vld), .quot_o(sq), .tag_o(d2b_tag)
  );

  // ---------------- S6: clamp and output ----------------
  logic               t_det0;
  logic signed [31:0] t_dp;
  logic [12:0]        t_vw, t_vh;
  logic               vis;
  logic signed [15:0] ctr;
  logic [15:0]        sz;
  logic signed [17:0] hs, hh, sc, ec, sr, er, vw18, vh18;

  always_comb begin
    {t_det0, t_dp, t_vw, t_vh} = d2_tag;
    vis = !t_det0 && (t_dp > 0);
    if (cq > NumW2'(32767))       ctr = 16'sh7fff;
    else if (cq < NumW2'(-32768)) ctr = 16'sh8000;
    else                          ctr = cq[15:0];
    if (sq > NumW2'(65535)) sz = 16'hffff;
    else                    sz = sq[15:0];
    // Screen sizes as signed values so that a negative end column compares correctly.
    vw18 = 18'($signed({1'b0, t_vw}));
    vh18 = 18'($signed({1'b0, t_vh}));
    hs = 18'(sz[15:1]);
    hh = 18'(t_vh[12:1]);
    sc = 18'(ctr) - hs;
    ec = 18'(ctr) + hs;
    sr = hh - hs;
    er = hh + hs;
    if (sc < 0) sc = '0;
    if (sr < 0) sr = '0;
    if (ec >= vw18) ec = vw18 - 18'sd1;
    if (er >= vh18) er = vh18 - 18'sd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else         done_o <= d2_vld;
  end

  always_ff @(posedge clk_i) begin
    visible_o    <= vis;
    depth_o      <= t_det0 ? '0 : t_dp;
    center_col_o <= vis ? ctr : '0;
    obj_size_o   <= vis ? sz : '0;
    start_col_o  <= vis ? sc[15:0] : '0;
    end_col_o    <= vis ? ec[15:0] : '0;
    start_row_o  <= vis ? sr[15:0] : '0;
    end_row_o    <= vis ? er[15:0] : '0;
  end

  // ---------------- checks ----------------
  // Parallel dividers must stay in lockstep.
  assert property (@(posedge clk_i) disable iff (!rst_ni) d1_vld == d1b_vld)
    else $error("tx/depth dividers out of step");
  assert property (@(posedge clk_i) disable iff (!rst_ni) d2_vld == d2b_vld)
    else $error("center/size dividers out of step");
  // A hidden sprite reports an empty rectangle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !visible_o |-> obj_size_o == '0 && center_col_o == '0)
    else $error("hidden sprite has nonzero bounds");

  // Unused tag bits.
  logic unused_tag;
  assign unused_tag = ^{d1_tag[Tag1W-1:2], d1_tag[0], d1b_tag, d2b_tag};

endmodule
